// ===== src/sjf_pkg.sv =====
// Shared types and constants of the shortest-job-first scheduler.
`timescale 1ns / 1ps

package sjf_pkg;

  // Fixed field widths of the job and result transactions
  localparam int unsigned BurstW     = 16;
  localparam int unsigned ArrivalW   = 16;
  localparam int unsigned JobIndexW  = 4;
  localparam int unsigned WaitW      = 20;
  localparam int unsigned TurnW      = 21;
  localparam int unsigned WaitTotW   = 24;
  localparam int unsigned TurnTotW   = 25;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store the accepted job
    logic scan_clear;  // restart a scan over the stored jobs
    logic scan_read;   // read the next stored job
    logic jump;        // idle: move time to the earliest pending arrival
    logic emit;        // run the picked job and present its result
    logic clear_set;   // set finished, return to an empty set
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;   // current read address is the last stored job
    logic found;       // the finished scan found an arrived job
    logic set_done;    // the next result is the final one of the set
    logic out_free;    // the result register can take a new result
  } status_t;

endpackage

// ===== src/shortest_job_first_scheduler.sv =====
// Top level of the non-preemptive shortest-job-first scheduler.
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_stall_o  burst_i, arrival_i, last_job_i
//   out      output     out_valid_o / out_stall_i job_index_o, wait_time_o,
//                                                turnaround_time_o, wait_total_o,
//                                                turnaround_total_o, last_result_o
//
// A job with last_job low is stored while the scheduler is idle. The closing
// job starts the schedule; each pick scans the n stored jobs through the
// store's single read port, and an idle jump adds one more scan of them.
// Input is stalled from the closing job until the final result is registered;
// a stalled output holds the result and pauses scheduling. Reset empties the set.
`timescale 1ns / 1ps

module shortest_job_first_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sjf_pkg::BurstW-1:0]    burst_i,
  input  logic [sjf_pkg::ArrivalW-1:0]  arrival_i,
  input  logic                          last_job_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sjf_pkg::JobIndexW-1:0] job_index_o,
  output logic [sjf_pkg::WaitW-1:0]     wait_time_o,
  output logic [sjf_pkg::TurnW-1:0]     turnaround_time_o,
  output logic [sjf_pkg::WaitTotW-1:0]  wait_total_o,
  output logic [sjf_pkg::TurnTotW-1:0]  turnaround_total_o,
  output logic                          last_result_o
);

  sjf_pkg::cmd_t    cmd;
  sjf_pkg::status_t status;

  // Sequencer
  sjf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_job_i (last_job_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, scan and result datapath
  sjf_datapath #(
    .MaxJobs (MAX_JOBS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .burst_i            (burst_i),
    .arrival_i          (arrival_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .job_index_o        (job_index_o),
    .wait_time_o        (wait_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .wait_total_o       (wait_total_o),
    .turnaround_total_o (turnaround_total_o),
    .last_result_o      (last_result_o)
  );

endmodule

// ===== src/sjf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sjf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sjf_datapath.sv =====
// Datapath: job store, scan and pick logic, time and totals, result register.
`timescale 1ns / 1ps

module sjf_datapath #(
  parameter int unsigned MaxJobs = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sjf_pkg::cmd_t                   cmd_i,
  output sjf_pkg::status_t                status_o,
  input  logic [sjf_pkg::BurstW-1:0]      burst_i,
  input  logic [sjf_pkg::ArrivalW-1:0]    arrival_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sjf_pkg::JobIndexW-1:0]   job_index_o,
  output logic [sjf_pkg::WaitW-1:0]       wait_time_o,
  output logic [sjf_pkg::TurnW-1:0]       turnaround_time_o,
  output logic [sjf_pkg::WaitTotW-1:0]    wait_total_o,
  output logic [sjf_pkg::TurnTotW-1:0]    turnaround_total_o,
  output logic                            last_result_o
);

  localparam int unsigned IdxW   = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CntW   = $clog2(MaxJobs + 1);
  localparam int unsigned TimeW  = sjf_pkg::ArrivalW + CntW;
  localparam int unsigned CalcW  = TimeW + 8;
  localparam int unsigned EntryW = sjf_pkg::BurstW + sjf_pkg::ArrivalW;

  // Set bookkeeping
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    emit_cnt_q, emit_cnt_d;
  logic [MaxJobs-1:0] done_q, done_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [sjf_pkg::WaitTotW-1:0] wsum_q, wsum_d;
  logic [sjf_pkg::TurnTotW-1:0] tsum_q, tsum_d;

  // Scan state
  logic [IdxW-1:0] scan_addr_q, scan_addr_d;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            found_q, found_d;
  logic            have_min_q, have_min_d;
  logic [IdxW-1:0]                 best_idx_q, best_idx_d;
  logic [sjf_pkg::BurstW-1:0]      best_burst_q, best_burst_d;
  logic [sjf_pkg::ArrivalW-1:0]    best_arr_q, best_arr_d;
  logic [sjf_pkg::ArrivalW-1:0]    min_arr_q, min_arr_d;

  // Result register
  logic out_valid_q, out_valid_d;
  logic [sjf_pkg::JobIndexW-1:0] job_index_q;
  logic [sjf_pkg::WaitW-1:0]     wait_time_q;
  logic [sjf_pkg::TurnW-1:0]     turn_time_q;
  logic [sjf_pkg::WaitTotW-1:0]  wait_tot_q;
  logic [sjf_pkg::TurnTotW-1:0]  turn_tot_q;
  logic                          last_res_q;

  // Store interface
  logic                         wr_en;
  logic [EntryW-1:0]            rd_data;
  logic [sjf_pkg::BurstW-1:0]   rd_burst;
  logic [sjf_pkg::ArrivalW-1:0] rd_arr;
  logic                         rd_arrived;

  // Result arithmetic
  logic [CalcW-1:0]     wait_ext, turn_ext;
  logic [IdxW+3:0]      idx_ext;
  logic                 set_done;
  logic [sjf_pkg::WaitTotW-1:0] wsum_next;
  logic [sjf_pkg::TurnTotW-1:0] tsum_next;

  // Job store: burst in the upper half, arrival in the lower half
  assign wr_en = cmd_i.load && (count_q < CntW'(MaxJobs));

  sjf_ram #(
    .Width (EntryW),
    .Depth (MaxJobs)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i ({burst_i, arrival_i}),
    .rd_en_i   (cmd_i.scan_read),
    .rd_addr_i (scan_addr_q),
    .rd_data_o (rd_data)
  );

  assign rd_burst   = rd_data[EntryW-1:sjf_pkg::ArrivalW];
  assign rd_arr     = rd_data[sjf_pkg::ArrivalW-1:0];
  assign rd_arrived = TimeW'(rd_arr) <= time_q;

  // Result of the picked job
  assign wait_ext  = CalcW'(time_q) - CalcW'(best_arr_q);
  assign turn_ext  = wait_ext + CalcW'(best_burst_q);
  assign idx_ext   = {4'b0000, best_idx_q};
  assign set_done  = CntW'(emit_cnt_q + 1'b1) == count_q;
  // totals including the picked job, independent of the end-of-set clear
  assign wsum_next = wsum_q + wait_ext[sjf_pkg::WaitTotW-1:0];
  assign tsum_next = tsum_q + turn_ext[sjf_pkg::TurnTotW-1:0];

  assign status_o.scan_last = CntW'(scan_addr_q) == CntW'(count_q - 1'b1);
  assign status_o.found     = found_q;
  assign status_o.set_done  = set_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Scan: keep the first arrived undone job with the least burst and the
  // earliest arrival of all undone jobs
  always_comb begin
    scan_addr_d  = scan_addr_q;
    found_d      = found_q;
    have_min_d   = have_min_q;
    best_idx_d   = best_idx_q;
    best_burst_d = best_burst_q;
    best_arr_d   = best_arr_q;
    min_arr_d    = min_arr_q;
    if (cmd_i.scan_clear) begin
      scan_addr_d = '0;
      found_d     = 1'b0;
      have_min_d  = 1'b0;
    end else if (cmd_i.scan_read) begin
      scan_addr_d = scan_addr_q + 1'b1;
    end
    if (rd_vld_q && !done_q[rd_idx_q]) begin
      if (rd_arrived && (!found_q || rd_burst < best_burst_q)) begin
        found_d      = 1'b1;
        best_idx_d   = rd_idx_q;
        best_burst_d = rd_burst;
        best_arr_d   = rd_arr;
      end
      if (!have_min_q || rd_arr < min_arr_q) begin
        have_min_d = 1'b1;
        min_arr_d  = rd_arr;
      end
    end
  end

  // Time, totals, done flags and job count
  always_comb begin
    count_d    = count_q;
    emit_cnt_d = emit_cnt_q;
    done_d     = done_q;
    time_d     = time_q;
    wsum_d     = wsum_q;
    tsum_d     = tsum_q;
    if (wr_en) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.jump) begin
      time_d = TimeW'(min_arr_q);
    end
    if (cmd_i.emit) begin
      time_d             = TimeW'(time_q + TimeW'(best_burst_q));
      done_d[best_idx_q] = 1'b1;
      wsum_d             = wsum_next;
      tsum_d             = tsum_next;
      emit_cnt_d         = emit_cnt_q + 1'b1;
    end
    if (cmd_i.clear_set) begin
      count_d    = '0;
      emit_cnt_d = '0;
      done_d     = '0;
      time_d     = '0;
      wsum_d     = '0;
      tsum_d     = '0;
    end
  end

  // Result handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      emit_cnt_q  <= '0;
      done_q      <= '0;
      time_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      have_min_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      emit_cnt_q  <= emit_cnt_d;
      done_q      <= done_d;
      time_q      <= time_d;
      wsum_q      <= wsum_d;
      tsum_q      <= tsum_d;
      scan_addr_q <= scan_addr_d;
      rd_vld_q    <= cmd_i.scan_read;
      rd_idx_q    <= scan_addr_q;
      found_q     <= found_d;
      have_min_q  <= have_min_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_burst_q <= best_burst_d;
    best_arr_q   <= best_arr_d;
    min_arr_q    <= min_arr_d;
    if (cmd_i.emit) begin
      job_index_q <= idx_ext[sjf_pkg::JobIndexW-1:0];
      wait_time_q <= wait_ext[sjf_pkg::WaitW-1:0];
      turn_time_q <= turn_ext[sjf_pkg::TurnW-1:0];
      wait_tot_q  <= wsum_next;
      turn_tot_q  <= tsum_next;
      last_res_q  <= set_done;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign job_index_o        = job_index_q;
  assign wait_time_o        = wait_time_q;
  assign turnaround_time_o  = turn_time_q;
  assign wait_total_o       = wait_tot_q;
  assign turnaround_total_o = turn_tot_q;
  assign last_result_o      = last_res_q;

  // A result is only produced for a job the scan actually picked
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> found_q && !done_q[best_idx_q])
    else $error("emit without a valid pick");

  // Jobs are never loaded while a scan is in flight
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !rd_vld_q && !cmd_i.scan_read)
    else $error("job load during scan");

  // An emitted result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten");

  // Job count stays within the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxJobs))
    else $error("job count beyond store depth");

endmodule

// ===== src/sjf_ctrl.sv =====
// Controller: sequences loading, scans, idle jumps and result emission.
`timescale 1ns / 1ps

module sjf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_job_i,
  output logic             in_stall_o,
  input  sjf_pkg::status_t status_i,
  output sjf_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_job_i) begin
            cmd_o.scan_clear = 1'b1;
            stall_d          = 1'b1;
            state_d          = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_read = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last read data is evaluated on this edge
        state_d = StEmit;
      end
      StEmit: begin
        if (!status_i.found) begin
          cmd_o.jump       = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d          = StScan;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.set_done) begin
            cmd_o.clear_set = 1'b1;
            stall_d         = 1'b0;
            state_d         = StIdle;
          end else begin
            cmd_o.scan_clear = 1'b1;
            state_d          = StScan;
          end
        end
      end
      default: begin
        state_d = StIdle;
        stall_d = 1'b0;
      end
    endcase
  end

  // State and registered stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

  // Input is taken exactly when the controller is idle
  a_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_q == (state_q != StIdle))
    else $error("input stall out of step with controller");

  // A closing job always starts a scan on the next cycle
  a_last_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i && last_job_i) |=> state_q == StScan)
    else $error("closing job did not start scheduling");

endmodule
